// ===== hw/rtl/irot_pkg.sv =====
// Shared types, request codes and widths for the interrupt redirect owner table.
package irot_pkg;

  localparam int NumVectorsDef = 256;

  localparam int TypeW    = 2;
  localparam int VectorW  = 8;
  localparam int HandlerW = 64;
  localparam int OwnerW   = 32;

  localparam logic [TypeW-1:0] REQ_SET    = 2'd0;
  localparam logic [TypeW-1:0] REQ_CLEAR  = 2'd1;
  localparam logic [TypeW-1:0] REQ_LOOKUP = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic init_wr;   // zero both memories at sweep index after reset
    logic accept;    // request word taken this cycle
    logic sweep_rd;  // issue owner read at sweep index
    logic load_out;  // finish request, load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;   // latched request is a clear
    logic sweep_last; // sweep index at the last vector
    logic out_free;   // result register can take a word
  } sts_t;

endpackage

// ===== hw/rtl/irot_if.sv =====
// Request and response channel interfaces.
interface irot_req_if;
  logic                          valid;
  logic                          ready;
  logic [irot_pkg::TypeW-1:0]    req_type;
  logic [irot_pkg::VectorW-1:0]  vector;
  logic [irot_pkg::HandlerW-1:0] handler_address;
  logic [irot_pkg::OwnerW-1:0]   owner_id;

  modport source (output valid, req_type, vector, handler_address, owner_id, input ready);
  modport sink (input valid, req_type, vector, handler_address, owner_id, output ready);
endinterface

interface irot_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [irot_pkg::HandlerW-1:0] found_handler;
  logic [irot_pkg::OwnerW-1:0]   found_owner;
  logic                          present;

  modport source (output valid, status, found_handler, found_owner, present, input ready);
  modport sink (input valid, status, found_handler, found_owner, present, output ready);
endinterface

// ===== hw/rtl/irot_datapath.sv =====
// Handler and owner memories, sweep counter and result register.
module irot_datapath #(
  parameter int NUM_VECTORS = irot_pkg::NumVectorsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  irot_pkg::cmd_t                cmd,
  output irot_pkg::sts_t                sts,
  input  logic [irot_pkg::TypeW-1:0]    in_type,
  input  logic [irot_pkg::VectorW-1:0]  in_vector,
  input  logic [irot_pkg::HandlerW-1:0] in_handler,
  input  logic [irot_pkg::OwnerW-1:0]   in_owner,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [irot_pkg::HandlerW-1:0] out_handler,
  output logic [irot_pkg::OwnerW-1:0]   out_owner,
  output logic                          out_present
);

  localparam int AW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;

  logic [irot_pkg::HandlerW-1:0] hmem [NUM_VECTORS];
  logic [irot_pkg::OwnerW-1:0]   omem [NUM_VECTORS];

  // latched request
  logic [irot_pkg::TypeW-1:0]    req_type;
  logic [AW-1:0]                 req_addr;
  logic                          req_in_table;
  logic [irot_pkg::HandlerW-1:0] req_handler;
  logic [irot_pkg::OwnerW-1:0]   req_owner;

  logic [AW-1:0]                 idx;
  logic                          cmp_pending;
  logic [AW-1:0]                 cmp_idx;

  logic [irot_pkg::HandlerW-1:0] rd_h;
  logic [irot_pkg::OwnerW-1:0]   rd_o;

  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          refused;
  logic                          wr_en;
  logic                          clr_en;
  logic                          h_we;
  logic [AW-1:0]                 h_addr;
  logic [irot_pkg::HandlerW-1:0] h_data;
  logic                          o_we;
  logic [AW-1:0]                 o_addr;
  logic [irot_pkg::OwnerW-1:0]   o_data;
  logic                          res_status;
  logic [irot_pkg::HandlerW-1:0] res_handler;
  logic [irot_pkg::OwnerW-1:0]   res_owner;
  logic                          res_present;

  assign rd_en   = cmd.accept | cmd.sweep_rd;
  assign rd_addr = cmd.accept ? in_vector[AW-1:0] : idx;

  assign refused = (req_owner != '0) && (rd_o != '0) && (req_owner != rd_o);
  assign clr_en  = cmp_pending && (rd_o == req_owner);

  // one write port per memory: init pass, clear sweep (handler memory only) or set
  assign h_we   = wr_en | clr_en | cmd.init_wr;
  assign h_addr = cmd.init_wr ? idx : (clr_en ? cmp_idx : req_addr);
  assign h_data = wr_en ? req_handler : '0;
  assign o_we   = wr_en | cmd.init_wr;
  assign o_addr = cmd.init_wr ? idx : req_addr;
  assign o_data = wr_en ? req_owner : '0;

  always_comb begin
    res_status  = 1'b0;
    res_handler = '0;
    res_owner   = '0;
    res_present = 1'b0;
    wr_en       = 1'b0;
    case (req_type)
      irot_pkg::REQ_SET: begin
        res_status = req_in_table & refused;
        wr_en      = cmd.load_out & req_in_table & ~refused;
      end
      irot_pkg::REQ_LOOKUP: begin
        if (req_in_table) begin
          res_handler = rd_h;
          res_owner   = rd_o;
          res_present = (rd_h != '0);
        end
      end
      default: ;
    endcase
  end

  // payload registers and memories
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type     <= in_type;
      req_addr     <= in_vector[AW-1:0];
      req_in_table <= ({1'b0, in_vector} < (irot_pkg::VectorW+1)'(NUM_VECTORS));
      req_handler  <= in_handler;
      req_owner    <= in_owner;
    end
    if (rd_en) begin
      rd_h <= hmem[rd_addr];
      rd_o <= omem[rd_addr];
    end
    if (h_we) hmem[h_addr] <= h_data;
    if (o_we) omem[o_addr] <= o_data;
    cmp_idx <= idx;
    if (cmd.load_out) begin
      out_status  <= res_status;
      out_handler <= res_handler;
      out_owner   <= res_owner;
      out_present <= res_present;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      cmp_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.accept) idx <= '0;
      else if (cmd.sweep_rd | cmd.init_wr) idx <= idx + AW'(1);
      cmp_pending <= cmd.sweep_rd;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign sts.is_clear   = (req_type == irot_pkg::REQ_CLEAR);
  assign sts.sweep_last = (idx == AW'(NUM_VECTORS - 1));
  assign sts.out_free   = ~out_valid | out_ready;

  a_present_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_present == (out_handler != '0)))
    else $error("present flag disagrees with handler");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status) |-> (out_handler == '0 && out_owner == '0 && !out_present))
    else $error("refused set carries lookup data");

  a_sweep_no_write: assert property (@(posedge clk) disable iff (rst)
    cmp_pending |-> !wr_en)
    else $error("entry write during clear sweep");

endmodule

// ===== hw/rtl/irot_ctrl.sv =====
// Request sequencer: clearing pass after reset, single pass for set, lookup or unused codes, or full clear sweep.
module irot_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_is_clear,
  input  irot_pkg::sts_t sts,
  output irot_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.init_wr  = (state == ST_INIT);
    cmd.accept   = (state == ST_IDLE) & in_valid;
    cmd.sweep_rd = (state == ST_SWEEP);
    cmd.load_out = ((state == ST_EXEC) || (state == ST_FLUSH)) & sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      case (state)
        ST_INIT: begin
          if (sts.sweep_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state <= in_is_clear ? ST_SWEEP : ST_EXEC;
        end
        ST_EXEC: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (sts.sweep_last) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          // last compare retires on entry to this state
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.init_wr, cmd.accept, cmd.sweep_rd, cmd.load_out}))
    else $error("overlapping datapath commands");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && sts.sweep_last) |=> (state == ST_FLUSH))
    else $error("sweep did not end at last vector");

  a_flush_is_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP || state == ST_FLUSH) |-> sts.is_clear)
    else $error("sweep running for a non-clear request");

endmodule

// ===== hw/rtl/interrupt_redirect_owner_table.sv =====
// Top level of the interrupt redirect owner table.
//
//   port  dir  word contents
//   req   in   req_type, vector, handler_address, owner_id
//   rsp   out  status, found_handler, found_owner, present
//
// Set, lookup and unused codes take one memory read, then the compare,
// write and result load. A clear walks the owner memory one vector per
// cycle. One request is in work at a time; a new word is taken while
// the previous result still waits in the rsp register. After synchronous
// reset a clearing pass zeroes both memories, one vector per cycle; req
// is not ready during that pass. A stalled rsp holds the block in its
// final step.
module interrupt_redirect_owner_table #(
  parameter int NUM_VECTORS = irot_pkg::NumVectorsDef
) (
  input logic  clk,
  input logic  rst,
  irot_req_if.sink   req,
  irot_rsp_if.source rsp
);

  irot_pkg::cmd_t cmd;
  irot_pkg::sts_t sts;

  irot_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_is_clear (req.req_type == irot_pkg::REQ_CLEAR),
    .sts         (sts),
    .cmd         (cmd)
  );

  irot_datapath #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_type     (req.req_type),
    .in_vector   (req.vector),
    .in_handler  (req.handler_address),
    .in_owner    (req.owner_id),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_handler (rsp.found_handler),
    .out_owner   (rsp.found_owner),
    .out_present (rsp.present)
  );

endmodule

// ===== bench/tb_interrupt_redirect_owner_table.sv =====
// Testbench for the interrupt redirect owner table: directed table, then random traffic.
module tb_interrupt_redirect_owner_table;

  localparam int TableDepth = irot_pkg::NumVectorsDef;
  localparam int RandWords  = 1400;
  localparam logic [irot_pkg::TypeW-1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [irot_pkg::TypeW-1:0]    kind;
    logic [irot_pkg::VectorW-1:0]  vec;
    logic [irot_pkg::HandlerW-1:0] handler;
    logic [irot_pkg::OwnerW-1:0]   owner;
  } req_word_t;

  typedef struct packed {
    logic                          status;
    logic [irot_pkg::HandlerW-1:0] handler;
    logic [irot_pkg::OwnerW-1:0]   owner;
    logic                          present;
  } rsp_word_t;

  typedef struct packed {
    req_word_t w;
    logic      typed;
    rsp_word_t exp;
  } plan_row_t;

  logic clk;
  logic rst;

  irot_req_if req_bus ();
  irot_rsp_if rsp_bus ();

  interrupt_redirect_owner_table u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  logic [irot_pkg::HandlerW-1:0] shadow_handler [TableDepth];
  logic [irot_pkg::OwnerW-1:0]   shadow_owner [TableDepth];
  rsp_word_t                     pending_rsp [$];
  int                            fails;
  int                            burst_left;

  // hand-typed expectation travels alongside the word on the bus
  logic      drv_typed;
  rsp_word_t drv_exp;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_interrupt_redirect_owner_table: FAIL");
    $finish;
  end

  // Apply one request to the shadow tables and return the response word.
  function automatic rsp_word_t redirect_apply(req_word_t w);
    rsp_word_t r;
    r = '0;
    case (w.kind)
      irot_pkg::REQ_SET: begin
        if (int'(w.vec) < TableDepth) begin
          if (w.owner != '0 && shadow_owner[w.vec] != '0 && w.owner != shadow_owner[w.vec]) begin
            r.status = 1'b1;
          end else begin
            shadow_handler[w.vec] = w.handler;
            shadow_owner[w.vec]   = w.owner;
          end
        end
      end
      irot_pkg::REQ_CLEAR: begin
        for (int i = 0; i < TableDepth; i++) begin
          if (shadow_owner[i] == w.owner) shadow_handler[i] = '0;
        end
      end
      irot_pkg::REQ_LOOKUP: begin
        if (int'(w.vec) < TableDepth) begin
          r.handler = shadow_handler[w.vec];
          r.owner   = shadow_owner[w.vec];
          r.present = (shadow_handler[w.vec] != '0);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t mk_row(logic [irot_pkg::TypeW-1:0] kind,
                                       logic [irot_pkg::VectorW-1:0] vec,
                                       logic [irot_pkg::HandlerW-1:0] handler,
                                       logic [irot_pkg::OwnerW-1:0] owner,
                                       logic typed, rsp_word_t exp);
    plan_row_t p;
    p.w     = '{kind, vec, handler, owner};
    p.typed = typed;
    p.exp   = exp;
    return p;
  endfunction

  // Sender: bursts of random length, random gaps, optional drain before the word.
  task automatic send_word(req_word_t w, logic typed, rsp_word_t exp, bit drain);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0 || drain) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      @(posedge clk);
    end
    req_bus.valid           <= 1'b1;
    req_bus.req_type        <= w.kind;
    req_bus.vector          <= w.vec;
    req_bus.handler_address <= w.handler;
    req_bus.owner_id        <= w.owner;
    drv_typed               <= typed;
    drv_exp                 <= exp;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Receiver stall pattern: segments of always-ready, random, and long stalls.
  initial begin
    int seg;
    int mode;
    int hold;
    rsp_bus.ready = 1'b0;
    seg  = 0;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (seg == 0) begin
        seg  = $urandom_range(30, 200);
        mode = $urandom_range(0, 2);
      end
      seg--;
      case (mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (hold != 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 15);
            rsp_bus.ready <= 1'b0;
          end else begin
            rsp_bus.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Predict on every accepted request word, check every accepted response word.
  always @(posedge clk) begin
    rsp_word_t predicted;
    rsp_word_t want;
    rsp_word_t got;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        predicted = redirect_apply('{req_bus.req_type, req_bus.vector,
                                     req_bus.handler_address, req_bus.owner_id});
        pending_rsp.push_back(drv_typed ? drv_exp : predicted);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = '{rsp_bus.status, rsp_bus.found_handler, rsp_bus.found_owner, rsp_bus.present};
        if (pending_rsp.size() == 0) begin
          $error("response word with no request pending");
          fails++;
        end else begin
          want = pending_rsp.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0h, got %0h", want.status, got.status);
            fails++;
          end
          if (got.handler !== want.handler) begin
            $error("found_handler: expected %h, got %h", want.handler, got.handler);
            fails++;
          end
          if (got.owner !== want.owner) begin
            $error("found_owner: expected %h, got %h", want.owner, got.owner);
            fails++;
          end
          if (got.present !== want.present) begin
            $error("present: expected %0h, got %0h", want.present, got.present);
            fails++;
          end
        end
      end
    end
  end

  initial begin
    plan_row_t                   plan [$];
    rsp_word_t                   none;
    req_word_t                   w;
    logic [irot_pkg::OwnerW-1:0] owner_pool [5];
    int                          pick;

    fails      = 0;
    burst_left = 0;
    none       = '0;
    drv_typed  = 1'b0;
    drv_exp    = '0;
    rst        = 1'b1;
    req_bus.valid           = 1'b0;
    req_bus.req_type        = '0;
    req_bus.vector          = '0;
    req_bus.handler_address = '0;
    req_bus.owner_id        = '0;
    for (int i = 0; i < TableDepth; i++) begin
      shadow_handler[i] = '0;
      shadow_owner[i]   = '0;
    end
    owner_pool = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'h8000_0001};

    // directed rows; typed expectations only where obvious
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd0, '0, '0, 1'b1, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd255, '0, '0, 1'b1, none));
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd0, '1, '1, 1'b1, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd0, '0, '0, 1'b1, '{1'b0, '1, '1, 1'b1}));
    // other owner on a held vector: refused
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd0, 64'h1, 32'd5, 1'b1,
                          '{1'b1, '0, '0, 1'b0}));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd0, '0, '0, 1'b0, none));
    // owner zero overwrites anything
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd0, 64'h1234, 32'd0, 1'b1, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd0, '0, '0, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd255, 64'hDEAD, 32'd7, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd255, 64'h0, 32'd7, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd255, '0, '0, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd128, 64'h8000_0000_0000_0000,
                          32'h8000_0000, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd1, 64'h5555_5555_5555_5555,
                          32'd0, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd2, 64'hAAAA_AAAA_AAAA_AAAA,
                          32'h5555_5555, 1'b0, none));
    // clear by owner zero hits every unowned entry
    plan.push_back(mk_row(irot_pkg::REQ_CLEAR, 8'd0, '0, 32'd0, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd1, '0, '0, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd2, '0, '0, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_CLEAR, 8'd77, '1, 32'h8000_0000, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd128, '0, '0, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_SET, 8'd128, 64'hAAAA_AAAA_AAAA_AAAA,
                          32'h8000_0000, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_CLEAR, 8'd0, '0, 32'd9, 1'b0, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd128, '0, '0, 1'b0, none));
    // unused code: no state change, all-zero word
    plan.push_back(mk_row(ReqUnused, 8'hFF, '1, '1, 1'b1, none));
    plan.push_back(mk_row(irot_pkg::REQ_LOOKUP, 8'd255, '1, '1, 1'b0, none));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].exp, 1'b0);

    for (int n = 0; n < RandWords; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) w.kind = irot_pkg::REQ_SET;
      else if (pick < 90) w.kind = irot_pkg::REQ_LOOKUP;
      else if (pick < 96) w.kind = irot_pkg::REQ_CLEAR;
      else w.kind = ReqUnused;
      // hot vectors near both ends so sets and lookups meet
      if ($urandom_range(0, 9) < 6) begin
        w.vec = ($urandom_range(0, 1) != 0) ? (irot_pkg::VectorW)'($urandom_range(0, 7))
                                            : (irot_pkg::VectorW)'($urandom_range(248, 255));
      end else begin
        w.vec = (irot_pkg::VectorW)'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) w.handler = '0;
      else if (pick == 1) w.handler = '1;
      else w.handler = {$urandom, $urandom};
      w.owner = ($urandom_range(0, 3) == 0) ? (irot_pkg::OwnerW)'($urandom)
                                           : owner_pool[$urandom_range(0, 4)];
      send_word(w, 1'b0, none, n == RandWords / 2);
    end
    req_bus.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TableDepth + 8) @(posedge clk);

    if (fails == 0) begin
      $display("tb_interrupt_redirect_owner_table: PASS");
    end else begin
      $display("tb_interrupt_redirect_owner_table: FAIL");
    end
    $finish;
  end

endmodule
